@@ src/mpm_pkg.sv @@
// Shared constants and types for the masked positive mean block.
// Field widths, accumulator sizing and the controller state encoding.
// No dependencies.
`timescale 1ns / 1ps

package mpm_pkg;

   // Pixel format and frame size limit
   localparam int PIXEL_BITS      = 32;
   localparam int MAX_PIXELS_LOG2 = 20;

   // Port field widths
   localparam int PIXEL_W    = 32;
   localparam int CONTRAST_W = 31;
   localparam int COUNT_W    = 21;

   // Packed stream widths, rounded up to whole bytes
   localparam int REQ_DATA_W = ((PIXEL_W + 1 + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((CONTRAST_W + 2 * COUNT_W + 1 + 7) / 8) * 8;

   // Accumulator widths: the sum of up to 2^MAX_PIXELS_LOG2 positive pixels,
   // held in at most 64 bits
   localparam int SUM_FULL_W = PIXEL_BITS - 1 + MAX_PIXELS_LOG2;
   localparam int SUM_W      = (SUM_FULL_W > 64) ? 64 : SUM_FULL_W;
   localparam int CNT_W      = MAX_PIXELS_LOG2 + 1;
   localparam int STEP_W     = $clog2(SUM_W + 1);

   localparam logic [CNT_W-1:0] PIXEL_LIMIT = CNT_W'(1) << MAX_PIXELS_LOG2;

   // Controller states
   typedef enum logic [1:0] {
      ST_ACCUM  = 2'b01,
      ST_DIVIDE = 2'b10
   } state_type;

endpackage

@@ src/masked_positive_mean.sv @@
// Masked positive pixel mean: frame accumulator plus a single serial divider.
// Depends on mpm_pkg for widths, limits and the state encoding.
`timescale 1ns / 1ps

// One pixel is taken per cycle while a frame streams in. The pixel that
// carries tlast is accumulated, then a restoring divider forms
// sum / positive count one quotient bit per cycle, SUM_W steps in all
// (51 with the default sizing), and then the result register is loaded.
// req_tready is low from the frame end until that load, so no pixel of the
// next frame is taken while the divider runs; a result register still
// waiting for the receiver holds req_tready low longer.
// The result sits in an output register, so the next frame may start
// streaming while it waits to be taken; a further frame end then waits for
// that register to drain before the new result is loaded. The mean is the
// truncated quotient, zero when no masked pixel was above zero. Counts stop
// at 2^MAX_PIXELS_LOG2 masked pixels; further masked pixels are dropped and
// raise the overflow flag.
module masked_positive_mean (
   input  logic                           clock,
   input  logic                           reset,
   // pixel [31:0], in_mask [32], zero fill above
   input  logic [mpm_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,   // frame_end
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // contrast [30:0], mask_count [51:31], positive_count [72:52],
   // overflowed [73], zero fill above
   output logic [mpm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready
);

   import mpm_pkg::*;

   state_type state_ff, state_in;

   // Frame accumulators
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] mask_cnt_ff, mask_cnt_in;
   logic [CNT_W-1:0] pos_cnt_ff, pos_cnt_in;
   logic             ovf_ff, ovf_in;

   // Divider operands and working registers
   logic [SUM_W-1:0]  dvd_ff, dvd_in;     // dividend shifting out, quotient in
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_pos_ff, div_pos_in;
   logic [CNT_W-1:0]  div_mask_ff, div_mask_in;
   logic              div_ovf_ff, div_ovf_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CONTRAST_W-1:0] contrast_ff, contrast_in;
   logic [COUNT_W-1:0]    out_mask_ff, out_mask_in;
   logic [COUNT_W-1:0]    out_pos_ff, out_pos_in;
   logic                  out_ovf_ff, out_ovf_in;

   logic                  req_xfer;
   logic                  rsp_free;
   logic                  div_done;
   logic [PIXEL_BITS-1:0] pix;
   logic                  pix_masked;
   logic                  pix_positive;
   logic                  at_limit;
   logic [SUM_W-1:0]      acc_sum;
   logic [CNT_W-1:0]      acc_mask;
   logic [CNT_W-1:0]      acc_pos;
   logic                  acc_ovf;
   logic [CNT_W:0]        partial;
   logic [CNT_W+1:0]      diff;
   logic                  fits;

   assign req_tready = (state_ff == ST_ACCUM);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign div_done   = (step_ff == STEP_W'(SUM_W));

   // Classify the incoming pixel
   assign pix          = req_tdata[PIXEL_BITS-1:0];
   assign pix_masked   = req_tdata[PIXEL_W];
   assign pix_positive = !pix[PIXEL_BITS-1] && (pix != '0);
   assign at_limit     = (mask_cnt_ff == PIXEL_LIMIT);

   // Accumulate the pixel, dropping masked pixels beyond the limit
   always_comb begin
      acc_sum  = sum_ff;
      acc_mask = mask_cnt_ff;
      acc_pos  = pos_cnt_ff;
      acc_ovf  = ovf_ff;
      if (pix_masked) begin
         if (at_limit) begin
            acc_ovf = 1'b1;
         end else begin
            acc_mask = mask_cnt_ff + CNT_W'(1);
            if (pix_positive) begin
               acc_sum = sum_ff + SUM_W'(pix[PIXEL_BITS-2:0]);
               acc_pos = pos_cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   // One restoring division step: shift in the next dividend bit, trial subtract
   assign partial = {rem_ff, dvd_ff[SUM_W-1]};
   assign diff    = {1'b0, partial} - {2'b00, div_pos_ff};
   assign fits    = !diff[CNT_W+1];

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      mask_cnt_in  = mask_cnt_ff;
      pos_cnt_in   = pos_cnt_ff;
      ovf_in       = ovf_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_pos_in   = div_pos_ff;
      div_mask_in  = div_mask_ff;
      div_ovf_in   = div_ovf_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      contrast_in  = contrast_ff;
      out_mask_in  = out_mask_ff;
      out_pos_in   = out_pos_ff;
      out_ovf_in   = out_ovf_ff;

      unique case (state_ff)
         ST_ACCUM: begin
            if (req_xfer) begin
               if (req_tlast) begin
                  // hand the frame totals to the divider and clear for the next frame
                  dvd_in      = acc_sum;
                  rem_in      = '0;
                  div_pos_in  = acc_pos;
                  div_mask_in = acc_mask;
                  div_ovf_in  = acc_ovf;
                  step_in     = '0;
                  sum_in      = '0;
                  mask_cnt_in = '0;
                  pos_cnt_in  = '0;
                  ovf_in      = 1'b0;
                  state_in    = ST_DIVIDE;
               end else begin
                  sum_in      = acc_sum;
                  mask_cnt_in = acc_mask;
                  pos_cnt_in  = acc_pos;
                  ovf_in      = acc_ovf;
               end
            end
         end
         ST_DIVIDE: begin
            if (!div_done) begin
               // advance one quotient bit
               rem_in  = fits ? diff[CNT_W-1:0] : partial[CNT_W-1:0];
               dvd_in  = {dvd_ff[SUM_W-2:0], fits};
               step_in = step_ff + STEP_W'(1);
            end else if (rsp_free) begin
               // load the result once the output register is free
               rsp_valid_in = 1'b1;
               contrast_in  = (div_pos_ff == '0) ? '0 : CONTRAST_W'(dvd_ff);
               out_mask_in  = COUNT_W'(div_mask_ff);
               out_pos_in   = COUNT_W'(div_pos_ff);
               out_ovf_in   = div_ovf_ff;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         sum_ff       <= '0;
         mask_cnt_ff  <= '0;
         pos_cnt_ff   <= '0;
         ovf_ff       <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         mask_cnt_ff  <= mask_cnt_in;
         pos_cnt_ff   <= pos_cnt_in;
         ovf_ff       <= ovf_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      div_pos_ff  <= div_pos_in;
      div_mask_ff <= div_mask_in;
      div_ovf_ff  <= div_ovf_in;
      contrast_ff <= contrast_in;
      out_mask_ff <= out_mask_in;
      out_pos_ff  <= out_pos_in;
      out_ovf_ff  <= out_ovf_in;
   end

   // Pack the result transfer
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_ovf_ff, out_pos_ff, out_mask_ff, contrast_ff});

endmodule
